/* design/slsel_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sprite line slot selector.
// Used by the RAM, the controller, the datapath and the top level; no dependencies.

package slsel_pkg;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Register decode uses the word address bit of paddr.
  localparam logic REG_FLIP_MODE = 1'b0;

  localparam int RAM_DEPTH = 128;
  localparam int RAM_AW    = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ZONE,
    ST_TEST,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    ADD_LVB,
    ADD_YSTART,
    ADD_YSTEP
  } add_sel_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    logic [1:0] rd_sel;
    logic     cap_en;
    logic [1:0] cap_sel;
    add_sel_t add_sel;
    logic     zone;
    logic     test;
    logic     emit;
  } ctl_t;

  typedef struct packed {
    logic hit;
    logic last;
  } sts_t;

endpackage

/* design/slsel_ram.sv */
`timescale 1ns / 1ps
// Sprite RAM: 128 bytes, one write and one registered read per cycle.
// Per-byte valid bits make unwritten bytes read as zero after reset.

module slsel_ram (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       we,
  input  logic [6:0] waddr,
  input  logic [7:0] wdata,
  input  logic       re,
  input  logic [6:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0]   mem [slsel_pkg::RAM_DEPTH];
  logic [slsel_pkg::RAM_DEPTH-1:0] valid_r;
  logic [7:0]   rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= valid_r[raddr] ? mem[raddr] : 8'h00;
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/slsel_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for one evaluate item: four RAM reads, zone test, draw commands.
// Depends on slsel_pkg for the state, control and status types.

module slsel_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              opcode,
  input  slsel_pkg::sts_t   sts,
  output slsel_pkg::ctl_t   ctl,
  output logic              busy
);

  slsel_pkg::state_t state_r, state_nxt;
  logic [2:0] rd_cnt_r, rd_cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= slsel_pkg::ST_IDLE;
      rd_cnt_r <= 3'd0;
    end else begin
      state_r  <= state_nxt;
      rd_cnt_r <= rd_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = 3'd0;
    unique case (state_r)
      slsel_pkg::ST_IDLE: begin
        if (start && opcode == slsel_pkg::OP_EVAL) begin
          state_nxt = slsel_pkg::ST_READ;
        end
      end
      slsel_pkg::ST_READ: begin
        if (rd_cnt_r == 3'd4) begin
          state_nxt = slsel_pkg::ST_ZONE;
        end else begin
          rd_cnt_nxt = rd_cnt_r + 3'd1;
        end
      end
      slsel_pkg::ST_ZONE: begin
        state_nxt = slsel_pkg::ST_TEST;
      end
      slsel_pkg::ST_TEST: begin
        state_nxt = sts.hit ? slsel_pkg::ST_EMIT : slsel_pkg::ST_IDLE;
      end
      slsel_pkg::ST_EMIT: begin
        if (sts.last) begin
          state_nxt = slsel_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = slsel_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ctl         = '0;
    ctl.add_sel = slsel_pkg::ADD_LVB;
    unique case (state_r)
      slsel_pkg::ST_IDLE: begin
        ctl.load = start && opcode == slsel_pkg::OP_EVAL;
      end
      slsel_pkg::ST_READ: begin
        ctl.rd_en   = rd_cnt_r != 3'd4;
        ctl.rd_sel  = rd_cnt_r[1:0];
        ctl.cap_en  = rd_cnt_r != 3'd0;
        ctl.cap_sel = 2'(rd_cnt_r - 3'd1);
      end
      slsel_pkg::ST_ZONE: begin
        ctl.add_sel = slsel_pkg::ADD_LVB;
        ctl.zone    = 1'b1;
      end
      slsel_pkg::ST_TEST: begin
        ctl.add_sel = slsel_pkg::ADD_YSTART;
        ctl.test    = 1'b1;
      end
      slsel_pkg::ST_EMIT: begin
        ctl.add_sel = slsel_pkg::ADD_YSTEP;
        ctl.emit    = 1'b1;
      end
      default: begin
        ctl = '0;
      end
    endcase
  end

  assign busy = state_r != slsel_pkg::ST_IDLE;

  a_eval_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && start && opcode == slsel_pkg::OP_EVAL) |=> state_r == slsel_pkg::ST_READ)
    else $error("evaluate transfer did not start the read sequence");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slsel_pkg::ST_READ && rd_cnt_r == 3'd4) |=> state_r == slsel_pkg::ST_ZONE)
    else $error("read sequence did not end in the zone step");

  a_miss_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slsel_pkg::ST_TEST && !sts.hit) |=> state_r == slsel_pkg::ST_IDLE)
    else $error("sprite out of zone still produced draw commands");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == slsel_pkg::ST_EMIT && sts.last) |=> !busy)
    else $error("sequencer kept running after the last draw command");

endmodule

/* design/slsel_dp.sv */
`timescale 1ns / 1ps
// Datapath: sprite selection, byte capture, zone test and draw command regs.
// One shared 10-bit adder serves the zone sum and every tile y position.

module slsel_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                flip,
  input  slsel_pkg::ctl_t     ctl,
  input  logic [7:0]          in_scanline,
  input  logic [4:0]          in_slot,
  input  logic [7:0]          rdata,
  output logic [6:0]          rd_addr,
  output slsel_pkg::sts_t     sts,
  output logic                out_valid,
  output logic [9:0]          out_tile_code,
  output logic [3:0]          out_colour,
  output logic [8:0]          out_x_pos,
  output logic signed [9:0]   out_y_pos,
  output logic                out_last_part
);

  logic [7:0] line, vcnt, v2c;
  logic [4:0] hcnt, idx;
  logic       nh7, cnt4, cnt3;
  logic [4:0] idx_r;
  logic [7:0] v2c_r;
  logic [7:0] d0_r, d1_r, d2_r, d3_r;
  logic [7:0] lvb_r;
  logic [9:0] add_a, add_b, sum;
  logic [1:0] hcode, parts;
  logic       inlen, vleq;
  logic [9:0] ystart_off;
  logic [8:0] code, xp;
  logic [9:0] code_r, y_r;
  logic [8:0] x_r;
  logic [1:0] p_r;
  logic       out_valid_r, out_last_r;
  logic [9:0] out_code_r, out_y_r;
  logic [3:0] out_colour_r;
  logic [8:0] out_x_r;

  always_comb begin
    line = in_scanline - 8'd7;
    vcnt = flip ? ~line : line;
    hcnt = in_slot + 5'd8;
    nh7  = ~hcnt[3];
    cnt4 = hcnt[4] ^ nh7;
    cnt3 = (vcnt[7] & cnt4) ^ nh7;
    idx  = {cnt4, cnt3, hcnt[2:0]};
    v2c  = flip ? (in_scanline - 8'd6) : (8'd5 - in_scanline);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      idx_r <= idx;
      v2c_r <= v2c;
    end
    if (ctl.cap_en) begin
      case (ctl.cap_sel)
        2'd0:    d0_r <= rdata;
        2'd1:    d1_r <= rdata;
        2'd2:    d2_r <= rdata;
        default: d3_r <= rdata;
      endcase
    end
  end

  assign rd_addr = {idx_r, ctl.rd_sel};

  always_comb begin
    hcode = d1_r[7:6];
    parts = {hcode[1], hcode[1] | hcode[0]};
    ystart_off = flip ? (10'd247 - {4'd0, parts, 4'd0}) : (10'd6 + {4'd0, parts, 4'd0});
  end

  always_comb begin
    case (ctl.add_sel)
      slsel_pkg::ADD_LVB: begin
        add_a = {2'b00, v2c_r};
        add_b = {2'b00, d2_r};
      end
      slsel_pkg::ADD_YSTART: begin
        add_a = flip ? ~{2'b00, d2_r} : {2'b00, d2_r};
        add_b = ystart_off;
      end
      default: begin
        add_a = y_r;
        add_b = flip ? 10'd16 : 10'h3f0;
      end
    endcase
    sum = add_a + add_b;
  end

  always_comb begin
    case (hcode)
      2'd0:    inlen = lvb_r[7:4] == 4'hf;
      2'd1:    inlen = lvb_r[7:5] == 3'h7;
      2'd2:    inlen = lvb_r[7:6] == 2'h3;
      default: inlen = 1'b1;
    endcase
    vleq = (~lvb_r) <= (~d2_r);
    code = {d0_r[7], d1_r[5], d0_r[6:0]};
    xp   = flip ? (9'd368 - {1'b0, d3_r}) : ({1'b0, d3_r} + 9'd128);
    xp   = xp ^ {d1_r[4], 8'd0};
  end

  assign sts.hit  = vleq && inlen;
  assign sts.last = p_r == 2'd0;

  always_ff @(posedge clk) begin
    if (ctl.zone) begin
      lvb_r <= sum[7:0];
    end
    if (ctl.test) begin
      y_r    <= sum;
      code_r <= {1'b0, code} + {8'd0, parts};
      p_r    <= parts;
      x_r    <= xp;
    end else if (ctl.emit) begin
      y_r    <= sum;
      code_r <= code_r - 10'd1;
      p_r    <= p_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_code_r   <= code_r;
      out_colour_r <= d1_r[3:0];
      out_x_r      <= x_r;
      out_y_r      <= y_r;
      out_last_r   <= p_r == 2'd0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_tile_code = out_code_r;
  assign out_colour    = out_colour_r;
  assign out_x_pos     = out_x_r;
  assign out_y_pos     = $signed(out_y_r);
  assign out_last_part = out_last_r;

endmodule

/* design/sprite_line_slot_selector_core.sv */
`timescale 1ns / 1ps
// Sprite line slot selector top level: APB register, sprite RAM, sequencer, datapath.
// A write transfer is taken while busy is low, and busy stays low; it gives no result.
// An evaluate transfer holds busy through four byte reads from the single RAM read port,
// the zone step, the test step and one emit step per draw command (0, 1, 2 or 4);
// the draw commands then appear one per cycle, the shared y adder stepping each y position.
// Synchronous active-low reset clears flip_mode, the sequencer and the RAM valid bits.

module sprite_line_slot_selector_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_opcode,
  input  logic [6:0]         in_ram_address,
  input  logic [7:0]         in_ram_data,
  input  logic [7:0]         in_scanline,
  input  logic [4:0]         in_slot,
  output logic               out_valid,
  output logic [9:0]         out_tile_code,
  output logic [3:0]         out_colour,
  output logic [8:0]         out_x_pos,
  output logic signed [9:0]  out_y_pos,
  output logic               out_last_part,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic              flip_r;
  logic              ram_we;
  logic [7:0]        rdata;
  logic [6:0]        rd_addr;
  slsel_pkg::ctl_t   ctl;
  slsel_pkg::sts_t   sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flip_r <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr[2] == slsel_pkg::REG_FLIP_MODE) begin
      flip_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == slsel_pkg::REG_FLIP_MODE) ? {31'd0, flip_r} : 32'd0;

  assign ram_we = start && !busy && in_opcode == slsel_pkg::OP_WRITE;

  slsel_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (in_ram_address),
    .wdata (in_ram_data),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  slsel_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (in_opcode),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  slsel_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .flip          (flip_r),
    .ctl           (ctl),
    .in_scanline   (in_scanline),
    .in_slot       (in_slot),
    .rdata         (rdata),
    .rd_addr       (rd_addr),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_tile_code (out_tile_code),
    .out_colour    (out_colour),
    .out_x_pos     (out_x_pos),
    .out_y_pos     (out_y_pos),
    .out_last_part (out_last_part)
  );

endmodule
